@@ sv/ray_march_cylinder_hit_unit_assert.svh @@
// ----------------------------------------------------------------------------
// ray_march_cylinder_hit_unit_assert.svh
// Assertion macros shared by the ray march cylinder hit unit.
// Each macro expects a clock named aclk and an active-low reset named aresetn.
// ----------------------------------------------------------------------------
`ifndef RAY_MARCH_CYLINDER_HIT_UNIT_ASSERT_SVH
`define RAY_MARCH_CYLINDER_HIT_UNIT_ASSERT_SVH

// same-cycle implication
`define RMCH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMCH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rmch_pkg.sv @@
// ----------------------------------------------------------------------------
// rmch_pkg
// Shared types, register indexes and reset constants of the ray march
// cylinder hit unit.
// ----------------------------------------------------------------------------
package rmch_pkg;

    localparam int STEP_W      = 10;
    localparam int FIELD_W     = 32;
    localparam int CFG_INDEX_W = 3;

    localparam int DEFAULT_COORD_WIDTH = 32;
    localparam int DEFAULT_TALLY_WIDTH = 32;

    localparam logic signed [31:0] RST_CENTER_X    = 32'sd0;
    localparam logic signed [31:0] RST_CENTER_Y    = 32'sd0;
    localparam logic signed [31:0] RST_CENTER_Z    = 32'sd196608;
    localparam logic [30:0]        RST_HALF_LENGTH = 31'd166461;
    localparam logic [30:0]        RST_RADIUS      = 31'd166461;
    localparam logic [STEP_W-1:0]  DEFAULT_MARCH_LIMIT = 10'd100;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_CENTER_Z    = 3'd2,
        REG_HALF_LENGTH = 3'd3,
        REG_RADIUS      = 3'd4,
        REG_MARCH_LIMIT = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_MARCH = 2'd1,
        ST_DONE  = 2'd2
    } state_t;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        half_length;
        logic [30:0]        radius;
        logic [STEP_W-1:0]  march_limit;
    } cfg_t;

    typedef struct packed {
        logic load;     // take a new ray
        logic advance;  // issue one march step
        logic capture;  // latch the ray outcome
        logic emit;     // load the output register
    } cmd_t;

    typedef struct packed {
        logic [STEP_W-1:0] issue_idx;
        logic              d_valid;
        logic              d_hit;
        logic [STEP_W-1:0] d_idx;
        logic              out_free;
    } status_t;

endpackage

@@ sv/rmch_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rmch_cfg_regs
// Configuration register file: cylinder geometry and march step limit.
// ----------------------------------------------------------------------------
module rmch_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rmch_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rmch_pkg::FIELD_W-1:0]       cfg_data,
    output rmch_pkg::cfg_t                     cfg
);

    rmch_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_x    <= rmch_pkg::RST_CENTER_X;
            cfg_reg.center_y    <= rmch_pkg::RST_CENTER_Y;
            cfg_reg.center_z    <= rmch_pkg::RST_CENTER_Z;
            cfg_reg.half_length <= rmch_pkg::RST_HALF_LENGTH;
            cfg_reg.radius      <= rmch_pkg::RST_RADIUS;
            cfg_reg.march_limit <= rmch_pkg::DEFAULT_MARCH_LIMIT;
        end else if (cfg_valid) begin
            case (cfg_index)
                rmch_pkg::REG_CENTER_X:    cfg_reg.center_x    <= cfg_data;
                rmch_pkg::REG_CENTER_Y:    cfg_reg.center_y    <= cfg_data;
                rmch_pkg::REG_CENTER_Z:    cfg_reg.center_z    <= cfg_data;
                rmch_pkg::REG_HALF_LENGTH: cfg_reg.half_length <= cfg_data[30:0];
                rmch_pkg::REG_RADIUS:      cfg_reg.radius      <= cfg_data[30:0];
                rmch_pkg::REG_MARCH_LIMIT: begin
                    cfg_reg.march_limit <= cfg_data[rmch_pkg::STEP_W-1:0];
                end
                default: ;
            endcase
        end
    end

endmodule

@@ sv/rmch_ctrl.sv @@
// ----------------------------------------------------------------------------
// rmch_ctrl
// March sequencer: accepts a ray, issues steps into the test pipeline,
// watches the pipeline tail for a hit or the last step, then hands the
// outcome to the output register.
// ----------------------------------------------------------------------------
`include "ray_march_cylinder_hit_unit_assert.svh"

module rmch_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rmch_pkg::STEP_W-1:0]     march_limit,
    input  rmch_pkg::status_t               status,
    output rmch_pkg::cmd_t                  cmd
);

    rmch_pkg::state_t state_reg;
    rmch_pkg::state_t state_next;
    logic             finish;
    logic             hit_in_march;

    // the pipeline tail shows either a hit or the final step of a miss
    assign finish = status.d_valid && (status.d_hit || (status.d_idx == march_limit));
    assign hit_in_march = (state_reg == rmch_pkg::ST_MARCH) && status.d_valid && status.d_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rmch_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rmch_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    // a zero limit takes no step and goes straight to the result
                    state_next = (march_limit == '0) ? rmch_pkg::ST_DONE
                                                     : rmch_pkg::ST_MARCH;
                end
            end
            rmch_pkg::ST_MARCH: begin
                if (finish) begin
                    state_next = rmch_pkg::ST_DONE;
                end
            end
            rmch_pkg::ST_DONE: begin
                if (status.out_free) begin
                    state_next = rmch_pkg::ST_IDLE;
                end
            end
            default: state_next = rmch_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        cmd.capture = 1'b0;
        cmd.emit    = 1'b0;
        case (state_reg)
            rmch_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            rmch_pkg::ST_MARCH: begin
                cmd.advance = (status.issue_idx != march_limit);
                cmd.capture = finish;
            end
            rmch_pkg::ST_DONE: begin
                cmd.emit = status.out_free;
            end
            default: ;
        endcase
    end

    `RMCH_ASSERT_NEXT(a_accept_blocks_next, s_tvalid && s_tready, !s_tready, "ray accepted twice")
    `RMCH_ASSERT_SAME(a_emit_needs_room, cmd.emit, status.out_free, "result over a pending one")
    `RMCH_ASSERT_NEXT(a_hit_ends_march, hit_in_march, !cmd.advance, "march went on after a hit")
    `RMCH_ASSERT_SAME(a_no_step_past_limit, cmd.advance, status.issue_idx < march_limit, "step past limit")

endmodule

@@ sv/rmch_datapath.sv @@
// ----------------------------------------------------------------------------
// rmch_datapath
// Marching position registers, four-stage inside test (step, offsets and
// z window, squares and box check, radius compare), result latch, tallies
// and the output register.
// ----------------------------------------------------------------------------
module rmch_datapath #(
    parameter int COORD_WIDTH = rmch_pkg::DEFAULT_COORD_WIDTH,
    parameter int TALLY_WIDTH = rmch_pkg::DEFAULT_TALLY_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rmch_pkg::cfg_t                    cfg,
    input  rmch_pkg::cmd_t                    cmd,
    output rmch_pkg::status_t                 status,
    input  logic signed [31:0]                start_x,
    input  logic signed [31:0]                start_y,
    input  logic signed [31:0]                start_z,
    input  logic signed [31:0]                step_x,
    input  logic signed [31:0]                step_y,
    input  logic signed [31:0]                step_z,
    input  logic                              restart_tally,
    input  logic                              m_tready,
    output logic                              out_valid,
    output logic                              out_hit,
    output logic [rmch_pkg::STEP_W-1:0]       out_steps_taken,
    output logic [31:0]                       out_rays_seen,
    output logic [31:0]                       out_hits_seen
);

    localparam int SW = rmch_pkg::STEP_W;
    // wide enough for any coordinate plus a 32-bit step or center
    localparam int EW = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 2;
    localparam logic signed [EW-1:0] CMAX =
        {{(EW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [EW-1:0] CMIN =
        {{(EW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [TALLY_WIDTH-1:0] TMAX = '1;
    localparam logic [TALLY_WIDTH+31:0] OUT_MAX = (TALLY_WIDTH+32)'(32'hFFFF_FFFF);

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] c;
        c = (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
        return c[COORD_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] sat_out(input logic [TALLY_WIDTH-1:0] t);
        logic [TALLY_WIDTH+31:0] w;
        w = (TALLY_WIDTH+32)'(t);
        return (w > OUT_MAX) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    // marching position and per-ray constants
    logic signed [COORD_WIDTH-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [COORD_WIDTH-1:0] pos_x_next, pos_y_next, pos_z_next;
    logic signed [31:0]            step_x_reg, step_y_reg, step_z_reg;
    logic signed [33:0]            z_lo_reg, z_hi_reg;
    logic signed [33:0]            z_lo_next, z_hi_next;
    logic [61:0]                   rsq_reg;
    logic [61:0]                   rsq_next;

    // stage a: position after the step
    logic              a_v_reg;
    logic [SW-1:0]     a_idx_reg;
    // stage b: axis offsets and z window
    logic              b_v_reg, b_zok_reg;
    logic [SW-1:0]     b_idx_reg;
    logic signed [EW-1:0] b_dx_reg, b_dy_reg;
    logic signed [EW-1:0] b_dx_next, b_dy_next;
    logic                 b_zok_next;
    // stage c: squares and box check
    logic              c_v_reg, c_zok_reg, c_rok_reg;
    logic [SW-1:0]     c_idx_reg;
    logic [62:0]       c_sqx_reg, c_sqy_reg;
    logic signed [EW-1:0] r_ext;
    logic signed [31:0]   dx32, dy32;
    logic signed [63:0]   sqx_next, sqy_next;
    logic                 c_rok_next;
    // stage d: radius compare
    logic              d_v_reg, d_hit_reg;
    logic [SW-1:0]     d_idx_reg;
    logic [63:0]       sq_sum;
    logic              d_hit_next;

    logic              res_hit_reg;
    logic [SW-1:0]     res_steps_reg;
    logic [TALLY_WIDTH-1:0] ray_tally_reg, hit_tally_reg;
    logic [TALLY_WIDTH-1:0] ray_tally_next, hit_tally_next;

    logic              out_valid_reg, out_hit_reg;
    logic [SW-1:0]     out_steps_reg;
    logic [31:0]       out_rays_reg, out_hits_reg;

    always_comb begin
        if (cmd.load) begin
            pos_x_next = sat_coord(EW'(start_x));
            pos_y_next = sat_coord(EW'(start_y));
            pos_z_next = sat_coord(EW'(start_z));
        end else begin
            pos_x_next = sat_coord(EW'(pos_x_reg) + EW'(step_x_reg));
            pos_y_next = sat_coord(EW'(pos_y_reg) + EW'(step_y_reg));
            pos_z_next = sat_coord(EW'(pos_z_reg) + EW'(step_z_reg));
        end
    end

    assign z_lo_next = 34'(cfg.center_z) - $signed({3'b000, cfg.half_length});
    assign z_hi_next = 34'(cfg.center_z) + $signed({3'b000, cfg.half_length});
    assign rsq_next  = cfg.radius * cfg.radius;

    assign b_dx_next  = EW'(pos_x_reg) - EW'(cfg.center_x);
    assign b_dy_next  = EW'(pos_y_reg) - EW'(cfg.center_y);
    assign b_zok_next = (EW'(pos_z_reg) > EW'(z_lo_reg)) && (EW'(pos_z_reg) < EW'(z_hi_reg));

    assign r_ext      = $signed(EW'({1'b0, cfg.radius}));
    assign c_rok_next = (b_dx_reg >= -r_ext) && (b_dx_reg <= r_ext) &&
                        (b_dy_reg >= -r_ext) && (b_dy_reg <= r_ext);
    // inside the box each offset fits 32 signed bits; outside, the square is unused
    assign dx32       = b_dx_reg[31:0];
    assign dy32       = b_dy_reg[31:0];
    assign sqx_next   = dx32 * dx32;
    assign sqy_next   = dy32 * dy32;

    assign sq_sum     = {1'b0, c_sqx_reg} + {1'b0, c_sqy_reg};
    assign d_hit_next = c_v_reg && c_zok_reg && c_rok_reg && (sq_sum <= {2'b00, rsq_reg});

    assign ray_tally_next = (ray_tally_reg == TMAX) ? ray_tally_reg : ray_tally_reg + 1'b1;
    assign hit_tally_next = (res_hit_reg && (hit_tally_reg != TMAX)) ?
                            hit_tally_reg + 1'b1 : hit_tally_reg;

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load || cmd.advance) begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
        end
        if (cmd.load) begin
            step_x_reg <= step_x;
            step_y_reg <= step_y;
            step_z_reg <= step_z;
            z_lo_reg   <= z_lo_next;
            z_hi_reg   <= z_hi_next;
            rsq_reg    <= rsq_next;
        end
        b_dx_reg   <= b_dx_next;
        b_dy_reg   <= b_dy_next;
        b_zok_reg  <= b_zok_next;
        b_idx_reg  <= a_idx_reg;
        c_sqx_reg  <= sqx_next[62:0];
        c_sqy_reg  <= sqy_next[62:0];
        c_rok_reg  <= c_rok_next;
        c_zok_reg  <= b_zok_reg;
        c_idx_reg  <= b_idx_reg;
        d_hit_reg  <= d_hit_next;
        d_idx_reg  <= c_idx_reg;
        if (cmd.emit) begin
            out_hit_reg   <= res_hit_reg;
            out_steps_reg <= res_steps_reg;
            out_rays_reg  <= sat_out(ray_tally_next);
            out_hits_reg  <= sat_out(hit_tally_next);
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg       <= 1'b0;
            b_v_reg       <= 1'b0;
            c_v_reg       <= 1'b0;
            d_v_reg       <= 1'b0;
            a_idx_reg     <= '0;
            res_hit_reg   <= 1'b0;
            res_steps_reg <= '0;
            ray_tally_reg <= '0;
            hit_tally_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                // a new ray flushes whatever is left in the pipeline
                a_v_reg       <= 1'b0;
                b_v_reg       <= 1'b0;
                c_v_reg       <= 1'b0;
                d_v_reg       <= 1'b0;
                a_idx_reg     <= '0;
                res_hit_reg   <= 1'b0;
                res_steps_reg <= '0;
                if (restart_tally) begin
                    ray_tally_reg <= '0;
                    hit_tally_reg <= '0;
                end
            end else begin
                a_v_reg <= cmd.advance;
                b_v_reg <= a_v_reg;
                c_v_reg <= b_v_reg;
                d_v_reg <= c_v_reg;
                if (cmd.advance) begin
                    a_idx_reg <= a_idx_reg + 1'b1;
                end
            end
            if (cmd.capture) begin
                res_hit_reg   <= d_hit_reg;
                res_steps_reg <= d_idx_reg;
            end
            if (cmd.emit) begin
                ray_tally_reg <= ray_tally_next;
                hit_tally_reg <= hit_tally_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.issue_idx = a_idx_reg;
    assign status.d_valid   = d_v_reg;
    assign status.d_hit     = d_hit_reg;
    assign status.d_idx     = d_idx_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign out_valid       = out_valid_reg;
    assign out_hit         = out_hit_reg;
    assign out_steps_taken = out_steps_reg;
    assign out_rays_seen   = out_rays_reg;
    assign out_hits_seen   = out_hits_reg;

endmodule

@@ sv/ray_march_cylinder_hit_unit.sv @@
// ----------------------------------------------------------------------------
// ray_march_cylinder_hit_unit
// Marches fixed-point rays against an axis-aligned cylinder and reports the
// first step that lands inside it, with saturating ray and hit tallies.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one transaction per ray, start point and step vector in
//   s_tdata, restart_tally in s_tuser (clears both tallies before the ray).
//   m_ channel: one transaction per ray, hit flag, steps taken and the two
//   tallies in m_tdata.
//   cfg channel: register writes by index, always ready; write only while
//   no ray is in flight.
//   a new ray is taken only after the previous ray's result has moved into
//   the output register.
//   the march loop issues one step per cycle into a four-stage test
//   pipeline (step add, offsets, 32x32 squares, radius compare); a zero
//   step limit answers without marching, with a miss and zero steps taken.
//   reset: configuration returns to its defaults, tallies clear, both
//   channels come up idle.
//   stall: the result waits in the output register while m_tready is low;
//   the next ray is still accepted and marched, and its result is held
//   until the output register frees up.
// ----------------------------------------------------------------------------
module ray_march_cylinder_hit_unit #(
    parameter int COORD_WIDTH = rmch_pkg::DEFAULT_COORD_WIDTH,
    parameter int TALLY_WIDTH = rmch_pkg::DEFAULT_TALLY_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // start_x, start_y, start_z, step_x, step_y, step_z (32 bits each)
    input  logic [191:0]                     s_tdata,
    // restart_tally
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit, steps_taken[10], rays_seen[32], hits_seen[32], zero pad[5]
    output logic [79:0]                      m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rmch_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rmch_pkg::FIELD_W-1:0]     cfg_data
);

    rmch_pkg::cfg_t    cfg;
    rmch_pkg::cmd_t    cmd;
    rmch_pkg::status_t status;

    logic                          out_hit;
    logic [rmch_pkg::STEP_W-1:0]   out_steps_taken;
    logic [31:0]                   out_rays_seen;
    logic [31:0]                   out_hits_seen;

    rmch_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rmch_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .march_limit (cfg.march_limit),
        .status      (status),
        .cmd         (cmd)
    );

    rmch_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .TALLY_WIDTH (TALLY_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .cmd             (cmd),
        .status          (status),
        .start_x         (s_tdata[31:0]),
        .start_y         (s_tdata[63:32]),
        .start_z         (s_tdata[95:64]),
        .step_x          (s_tdata[127:96]),
        .step_y          (s_tdata[159:128]),
        .step_z          (s_tdata[191:160]),
        .restart_tally   (s_tuser),
        .m_tready        (m_tready),
        .out_valid       (m_tvalid),
        .out_hit         (out_hit),
        .out_steps_taken (out_steps_taken),
        .out_rays_seen   (out_rays_seen),
        .out_hits_seen   (out_hits_seen)
    );

    assign m_tdata = {5'b00000, out_hits_seen, out_rays_seen, out_steps_taken, out_hit};

endmodule
